// ===== design/analog_key_press_qualifier_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Analog key press qualifier - assertion macros
// Shared property wrappers for the qualifier's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ANALOG_KEY_PRESS_QUALIFIER_UNIT_DEFINES_SVH
`define ANALOG_KEY_PRESS_QUALIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AKPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AKPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/akpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Analog key press qualifier - package
// Widths, codes and shared types of the qualifier.
// ----------------------------------------------------------------------------
package akpq_pkg;

    localparam int IDX_W        = 2;
    localparam int SAMPLE_W     = 12;
    localparam int LEVEL_COUNT  = 4;
    localparam int CFG_ADDR_W   = 3;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;
    localparam int NUM_SWITCHES_DEF = 4;
    localparam int Q_DEPTH_DEF  = 4;
    localparam int STAY_MARGIN  = 3;

    localparam logic [SAMPLE_W-1:0] ACT_LEVEL_RST = 12'd2048;
    localparam logic [SAMPLE_W-1:0] REL_LEVEL_RST = 12'd1536;

    localparam logic CFG_BANK_ACT = 1'b0;
    localparam logic CFG_BANK_REL = 1'b1;

    typedef enum logic [1:0] {
        ZONE_ABOVE = 2'd0,
        ZONE_MID   = 2'd1,
        ZONE_DEEP  = 2'd2
    } t_zone;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_DOWN = 2'd1,
        TURN_UP   = 2'd2
    } t_turn;

    typedef struct packed {
        logic [IDX_W-1:0]    switch_id;
        logic [SAMPLE_W-1:0] sample;
        t_zone               zone;
        logic                known;
    } t_item;

    typedef struct packed {
        t_turn            turn;
        logic             going_down;
        t_zone            zone;
        logic             pressed;
        logic [IDX_W-1:0] switch_id;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

// ===== design/akpq_front.sv =====
// ----------------------------------------------------------------------------
// Analog key press qualifier - front end
// Holds the level registers and classifies each incoming request into a zone.
// ----------------------------------------------------------------------------
module akpq_front
    import akpq_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SAMPLE_W-1:0]   i_cfg_wdata,
    input  logic [IDX_W-1:0]      i_switch_index,
    input  logic [SAMPLE_W-1:0]   i_position_sample,
    output t_item                 o_item
);

    logic [SAMPLE_W-1:0] r_act_level [LEVEL_COUNT];
    logic [SAMPLE_W-1:0] r_rel_level [LEVEL_COUNT];
    logic [SAMPLE_W-1:0] w_act;
    logic [SAMPLE_W-1:0] w_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_act_level[i] <= ACT_LEVEL_RST;
                r_rel_level[i] <= REL_LEVEL_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr[CFG_ADDR_W-1])
                CFG_BANK_ACT: r_act_level[i_cfg_addr[IDX_W-1:0]] <= i_cfg_wdata;
                CFG_BANK_REL: r_rel_level[i_cfg_addr[IDX_W-1:0]] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_act = r_act_level[i_switch_index];
    assign w_rel = r_rel_level[i_switch_index];

    always_comb begin
        o_item.switch_id = i_switch_index;
        o_item.sample    = i_position_sample;
        o_item.known     = ({1'b0, i_switch_index} < (IDX_W+1)'(NUM_SWITCHES));
        if (i_position_sample < w_rel) begin
            o_item.zone = ZONE_DEEP;
        end else if (i_position_sample < w_act) begin
            o_item.zone = ZONE_MID;
        end else begin
            o_item.zone = ZONE_ABOVE;
        end
    end

endmodule

// ===== design/akpq_fifo.sv =====
// ----------------------------------------------------------------------------
// Analog key press qualifier - request queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module akpq_fifo
    import akpq_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_item    i_item,
    input  logic     i_pop,
    output t_item    o_item,
    output t_q_flags o_flags
);

    localparam int PTR_W = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd_ptr[PTR_W-1:0]];
    assign o_flags.empty = (r_wr_ptr == r_rd_ptr);
    assign o_flags.full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W])
                        && (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);

endmodule

// ===== design/akpq_back.sv =====
// ----------------------------------------------------------------------------
// Analog key press qualifier - back end
// Tracks per-switch history, decides turn and press, registers the result.
// ----------------------------------------------------------------------------
module akpq_back
    import akpq_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_avail,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [SAMPLE_W-1:0] r_last_sample [NUM_SWITCHES];
    t_zone               r_last_zone   [NUM_SWITCHES];
    logic                r_last_down   [NUM_SWITCHES];
    logic                r_valid;
    t_result             r_result;

    logic [SAMPLE_W-1:0] w_prev;
    t_zone               w_prev_zone;
    logic                w_prev_down;
    logic                w_down;
    logic                w_staying;
    t_turn               w_turn;
    t_result             n_result;

    always_comb begin
        w_prev      = '0;
        w_prev_zone = ZONE_ABOVE;
        w_prev_down = 1'b0;
        for (int i = 0; i < NUM_SWITCHES; i++) begin
            if (i_item.switch_id == IDX_W'(i)) begin
                w_prev      = r_last_sample[i];
                w_prev_zone = r_last_zone[i];
                w_prev_down = r_last_down[i];
            end
        end
    end

    always_comb begin
        w_down    = (i_item.sample < w_prev);
        w_staying = (i_item.zone == w_prev_zone)
                 && ({1'b0, i_item.sample}
                     < ({1'b0, w_prev} + (SAMPLE_W+1)'(STAY_MARGIN)));
        w_turn = TURN_NONE;
        if (!w_staying) begin
            if (w_down && !w_prev_down) begin
                w_turn = TURN_DOWN;
            end else if (!w_down && w_prev_down) begin
                w_turn = TURN_UP;
            end
        end
        n_result.switch_id  = i_item.switch_id;
        n_result.zone       = ZONE_ABOVE;
        n_result.going_down = 1'b0;
        n_result.turn       = TURN_NONE;
        n_result.pressed    = 1'b0;
        if (i_item.known) begin
            n_result.zone       = i_item.zone;
            n_result.going_down = w_down;
            n_result.turn       = w_turn;
            case (i_item.zone)
                ZONE_DEEP: n_result.pressed = 1'b1;
                ZONE_MID:  n_result.pressed = (w_turn != TURN_UP);
                default:   n_result.pressed = 1'b0;
            endcase
        end
    end

    assign o_pop = i_avail && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                r_last_sample[i] <= '0;
                r_last_zone[i]   <= ZONE_ABOVE;
                r_last_down[i]   <= 1'b0;
            end
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            for (int i = 0; i < NUM_SWITCHES; i++) begin
                if (o_pop && i_item.known && (i_item.switch_id == IDX_W'(i))) begin
                    r_last_sample[i] <= i_item.sample;
                    r_last_zone[i]   <= i_item.zone;
                    r_last_down[i]   <= w_down;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== design/analog_key_press_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// Analog key press qualifier unit
// Rapid-trigger press qualification of analog key position samples.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: switch index and 12-bit position
// sample. Each request yields exactly one result on the m_axis channel:
// switch id, pressed, zone, going-down flag and turn code.
// Levels must be written through the i_cfg_* port only while the unit is
// idle (not enforced); index 0..3 are actuation, 4..7 release levels.
// A request passes through the queue, then the output register. Throughput
// is one request per cycle while m_axis_tready is high, set by the back-end
// history update, which reads and writes its switch state once per cycle.
// A request queue of QUEUE_DEPTH entries sits between classification and
// history update; s_axis_tready drops only when that queue is full, so a
// stalled receiver holds the registered result while the queue fills.
// Reset clears the queue, the output valid flag and the switch history, and
// loads the default levels.
// ----------------------------------------------------------------------------
`include "analog_key_press_qualifier_unit_defines.svh"

module analog_key_press_qualifier_unit
    import akpq_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF,
    parameter int QUEUE_DEPTH  = Q_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [SAMPLE_W-1:0]    i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] switch_index, [13:2] position_sample, [15:14] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] switch_id, [2] pressed, [4:3] zone, [5] going_down, [7:6] turn
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_item    w_front_item;
    t_item    w_head_item;
    t_q_flags w_q_flags;
    logic     w_push;
    logic     w_pop;
    t_result  w_result;

    akpq_front #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_switch_index   (s_axis_tdata[IDX_W-1:0]),
        .i_position_sample(s_axis_tdata[IDX_W+SAMPLE_W-1:IDX_W]),
        .o_item           (w_front_item)
    );

    assign s_axis_tready = !w_q_flags.full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    akpq_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_front_item),
        .i_pop  (w_pop),
        .o_item (w_head_item),
        .o_flags(w_q_flags)
    );

    akpq_back #(
        .NUM_SWITCHES(NUM_SWITCHES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!w_q_flags.empty),
        .i_item  (w_head_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result(w_result)
    );

    assign m_axis_tdata = w_result;

    `AKPQ_ASSERT_NOW(a_pop_needs_entry, i_clk, i_rst_n, w_pop, !w_q_flags.empty,
        "pop from empty queue")
    `AKPQ_ASSERT_NOW(a_deep_is_pressed, i_clk, i_rst_n,
        m_axis_tvalid && (w_result.zone == ZONE_DEEP), w_result.pressed,
        "deep zone not pressed")
    `AKPQ_ASSERT_NOW(a_unknown_switch_quiet, i_clk, i_rst_n,
        m_axis_tvalid && ({1'b0, w_result.switch_id} >= (IDX_W+1)'(NUM_SWITCHES)),
        m_axis_tdata[OUT_TDATA_W-1:IDX_W] == '0, "unknown switch result not zero")
    `AKPQ_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(w_result),
        "stalled result changed")

endmodule
